/* design/sp12_pkg.sv */
// constants, types and round functions for the 12-bit small-scale present cipher
// used by small_present_12bit_cipher_core, no dependencies
package sp12_pkg;

  localparam int ROUNDS   = 10;
  localparam int BLK_W    = 12;
  localparam int KEY_W    = 80;
  localparam int KLO_W    = 64;
  localparam int KHI_W    = 16;
  localparam int RK_IDX_W = $clog2(ROUNDS + 1);

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [RK_IDX_W-1:0] rk_idx_t;
  typedef logic [0:0] cfg_idx_t;

  localparam cfg_idx_t CFG_KEY_LOW  = 1'b0;
  localparam cfg_idx_t CFG_KEY_HIGH = 1'b1;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };
  localparam logic [3:0] SBOX_INV [16] = '{
    4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
    4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
  };

  function automatic blk_t sub_fwd(blk_t x);
    return {SBOX[x[11:8]], SBOX[x[7:4]], SBOX[x[3:0]]};
  endfunction

  function automatic blk_t sub_inv(blk_t x);
    return {SBOX_INV[x[11:8]], SBOX_INV[x[7:4]], SBOX_INV[x[3:0]]};
  endfunction

  // bit b moves to 3b mod 11, bit 11 stays
  function automatic blk_t perm_fwd(blk_t x);
    blk_t r;
    r = '0;
    r[11] = x[11];
    for (int b = 0; b < 11; b++) begin
      r[(3 * b) % 11] = x[b];
    end
    return r;
  endfunction

  // bit b moves to 4b mod 11, bit 11 stays
  function automatic blk_t perm_inv(blk_t x);
    blk_t r;
    r = '0;
    r[11] = x[11];
    for (int b = 0; b < 11; b++) begin
      r[(4 * b) % 11] = x[b];
    end
    return r;
  endfunction

  function automatic blk_t do_round(blk_t x, logic dec, blk_t k_enc, blk_t k_dec);
    blk_t r;
    if (dec) begin
      r = sub_inv(perm_inv(x ^ k_dec));
    end else begin
      r = perm_fwd(sub_fwd(x ^ k_enc));
    end
    return r;
  endfunction

  // one key schedule pass with counter i
  function automatic key_t key_step(key_t k, logic [4:0] i);
    key_t r;
    r = {k[18:0], k[79:19]};
    r[79:76] = SBOX[r[79:76]];
    r[15] = r[15] ^ i[0];
    r[19:16] = r[19:16] ^ i[4:1];
    return r;
  endfunction

  // round key with nibbles in reversed order
  function automatic blk_t rk_of(key_t k);
    return {k[3:0], k[7:4], k[11:8]};
  endfunction

endpackage

/* design/small_present_12bit_cipher_core.sv */
// top level of the 12-bit small-scale present cipher: key schedule and round pipeline
// depends on sp12_pkg
//
// usage:
//   cfg channel writes the 80-bit master key: index 0 takes bits 63:0, index 1 takes
//   bits 79:64 from cfg_data[15:0]; other bits of the data are dropped. cfg_ready is
//   always high.
//   in channel carries one item: in_func (0 encrypt, 1 decrypt) and in_block_in.
//   out channel returns out_block_out, one result per item, in order.
//   after reset and after every key write the round keys are rebuilt, one schedule
//   pass per cycle; in_ready stays low while this runs.
//   rounds are unrolled, one register stage per round; the final key add sits after the
//   last stage register. one item per cycle is taken while the output is free and
//   the round keys are not being rebuilt. when out_valid is high and the receiver holds
//   out_ready low the whole pipeline stops and in_ready drops; nothing is lost or
//   repeated. reset clears all valid bits and the key.
module small_present_12bit_cipher_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  sp12_pkg::cfg_idx_t       cfg_index,
  input  logic [sp12_pkg::KLO_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  sp12_pkg::blk_t           in_block_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output sp12_pkg::blk_t           out_block_out
);

  localparam int R = sp12_pkg::ROUNDS;

  sp12_pkg::key_t    key_r;
  sp12_pkg::key_t    ks_key_r;
  sp12_pkg::key_t    ks_key_nxt;
  sp12_pkg::rk_idx_t ks_cnt_r;
  logic              ks_load_r;
  logic              ks_busy_r;
  sp12_pkg::blk_t    rk_r [0:R];

  logic              adv;
  logic              cfg_acc;
  logic              st_v_r [1:R];
  logic              st_f_r [1:R];
  sp12_pkg::blk_t    st_x_r [1:R];
  sp12_pkg::blk_t    src_x [0:R-1];
  logic              src_f [0:R-1];
  sp12_pkg::blk_t    rnd_x [0:R-1];

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // master key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        sp12_pkg::CFG_KEY_LOW:  key_r[63:0]  <= cfg_data;
        sp12_pkg::CFG_KEY_HIGH: key_r[79:64] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // key schedule sequencer, one pass per cycle
  assign ks_key_nxt = sp12_pkg::key_step(ks_key_r, 5'(ks_cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_load_r <= 1'b1;
      ks_busy_r <= 1'b1;
      ks_cnt_r  <= '0;
    end else if (cfg_acc) begin
      ks_load_r <= 1'b1;
      ks_busy_r <= 1'b1;
      ks_cnt_r  <= '0;
    end else if (ks_load_r) begin
      ks_load_r <= 1'b0;
      ks_cnt_r  <= '0;
    end else if (ks_busy_r) begin
      if (ks_cnt_r == sp12_pkg::RK_IDX_W'(R)) begin
        ks_busy_r <= 1'b0;
      end else begin
        ks_cnt_r <= ks_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ks_load_r) begin
      ks_key_r <= key_r;
    end else if (ks_busy_r) begin
      ks_key_r         <= ks_key_nxt;
      rk_r[ks_cnt_r]   <= sp12_pkg::rk_of(ks_key_nxt);
    end
  end

  // round pipeline
  assign adv      = !st_v_r[R] || out_ready;
  assign in_ready = adv && !ks_busy_r && !ks_load_r;

  always_comb begin
    src_x[0] = in_block_in;
    src_f[0] = in_func;
    for (int s = 1; s < R; s++) begin
      src_x[s] = st_x_r[s];
      src_f[s] = st_f_r[s];
    end
    for (int s = 0; s < R; s++) begin
      rnd_x[s] = sp12_pkg::do_round(src_x[s], src_f[s], rk_r[s], rk_r[R - s]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= R; s++) begin
        st_v_r[s] <= 1'b0;
      end
    end else if (adv) begin
      st_v_r[1] <= in_valid && in_ready;
      for (int s = 2; s <= R; s++) begin
        st_v_r[s] <= st_v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 1; s <= R; s++) begin
        st_x_r[s] <= rnd_x[s-1];
        st_f_r[s] <= src_f[s-1];
      end
    end
  end

  assign out_valid     = st_v_r[R];
  assign out_block_out = st_x_r[R] ^ (st_f_r[R] ? rk_r[0] : rk_r[R]);

  // checks
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> !in_ready)
    else $error("item accepted right after a key write");

  a_load_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ks_load_r && !cfg_acc |=> ks_busy_r && !ks_load_r && (ks_cnt_r == '0))
    else $error("key schedule did not start after load");

  a_sched_done: assert property (@(posedge clk) disable iff (!rst_n)
    ks_busy_r && !ks_load_r && !cfg_acc && (ks_cnt_r == sp12_pkg::RK_IDX_W'(R))
    |=> !ks_busy_r)
    else $error("key schedule ran past the last round key");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    st_v_r[R] && !out_ready |=> st_v_r[R] && $stable(st_x_r[R]) && $stable(st_f_r[R]))
    else $error("last stage changed during a stall");

endmodule
